### rtl/brf_pkg.sv
// Shared types and constants for the byte ring FIFO.
package brf_pkg;

  localparam int DEPTH  = 64;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int SIZE_W = 7;
  localparam int LVL_W  = 6;
  localparam int BYTE_W = 8;
  localparam int ACT_W  = 2;
  localparam int STS_W  = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_DRAIN = 2'd3
  } brf_act_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } brf_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT
  } brf_state_t;

  typedef struct packed {
    logic        load_item;
    logic        wr_en;
    logic        clr;
    logic        rd_issue;
    logic        emit;
    logic        emit_byte;
    brf_status_t status;
    logic        last;
  } brf_cmd_t;

  typedef struct packed {
    brf_act_t act;
    logic     full;
    logic     empty;
    logic     out_free;
  } brf_sts_t;

endpackage

### rtl/brf_if.sv
// Channel interfaces: input items, results and the size register write.
interface brf_in_if import brf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [BYTE_W-1:0] write_byte;

  modport source (output valid, output action, output write_byte, input ready);
  modport sink   (input valid, input action, input write_byte, output ready);
endinterface

interface brf_out_if import brf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_byte;
  logic [STS_W-1:0]  status;
  logic              last;
  logic [LVL_W-1:0]  fill_level;

  modport source (output valid, output read_byte, output status, output last,
                  output fill_level, input ready);
  modport sink   (input valid, input read_byte, input status, input last,
                  input fill_level, output ready);
endinterface

interface brf_cfg_if import brf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] buffer_size;

  modport source (output valid, output buffer_size, input ready);
  modport sink   (input valid, input buffer_size, output ready);
endinterface

### rtl/byte_ring_fifo_core.sv
// Top level of the byte ring FIFO: controller, datapath and channel wiring.
// Byte FIFO of up to 64 slots, wrapping at the configured size and holding at most size-1
// bytes. A read of a stored byte goes through capture, slot memory read and result; a drain
// streams one byte per cycle, while the output register is free, through the single
// registered read port of the slot memory. A new item is taken only in idle, once the last
// is done. Results wait in an output register; any stall there holds the controller.
// Writing the size register empties the buffer; no clearing pass is needed after reset.
module byte_ring_fifo_core import brf_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  brf_in_if.sink    in_ch,
  brf_out_if.source out_ch,
  brf_cfg_if.sink   cfg_ch
);

  brf_cmd_t cmd;
  brf_sts_t sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  brf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  brf_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_action     (in_ch.action),
    .in_write_byte (in_ch.write_byte),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

### rtl/brf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/brf_dp.sv
// Datapath: pointers, size register, slot memory and result register.
module brf_dp import brf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [BYTE_W-1:0] in_write_byte,
  brf_out_if.source         out_ch,
  brf_cfg_if.sink           cfg_ch,
  input  brf_cmd_t          cmd,
  output brf_sts_t          sts
);

  localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(DEPTH);

  brf_act_t          act_r;
  logic [BYTE_W-1:0] wbyte_r;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PTR_W-1:0]  wp_adv, rp_adv;
  logic [LVL_W-1:0]  fill_cur, fill_after;
  logic [BYTE_W-1:0] ram_rdata;
  logic              cfg_wr;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [STS_W-1:0]  out_status_r;
  logic              out_last_r;
  logic [LVL_W-1:0]  out_level_r;

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                           input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] n;
    n = SIZE_W'(p) + SIZE_W'(1);
    return (n >= s) ? '0 : n[PTR_W-1:0];
  endfunction

  function automatic logic [LVL_W-1:0] fill(input logic [PTR_W-1:0] w,
                                            input logic [PTR_W-1:0] r,
                                            input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] d;
    if (w >= r) begin
      d = SIZE_W'(w) - SIZE_W'(r);
    end else begin
      d = SIZE_W'(w) + s - SIZE_W'(r);
    end
    return d[LVL_W-1:0];
  endfunction

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;

  assign wp_adv = adv(wp_r, size_r);
  assign rp_adv = adv(rp_r, size_r);

  always_comb begin
    size_nxt = size_r;
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    if (cfg_wr) begin
      if (cfg_ch.buffer_size < SIZE_MIN) begin
        size_nxt = SIZE_MIN;
      end else if (cfg_ch.buffer_size > SIZE_MAX) begin
        size_nxt = SIZE_MAX;
      end else begin
        size_nxt = cfg_ch.buffer_size;
      end
      wp_nxt = '0;
      rp_nxt = '0;
    end else begin
      if (cmd.clr) begin
        wp_nxt = '0;
        rp_nxt = '0;
      end
      if (cmd.wr_en) begin
        wp_nxt = wp_adv;
      end
      if (cmd.rd_issue) begin
        rp_nxt = rp_adv;
      end
    end
  end

  assign fill_cur   = fill(wp_r, rp_r, size_r);
  assign fill_after = fill(wp_nxt, rp_nxt, size_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_MAX;
      wp_r   <= '0;
      rp_r   <= '0;
    end else begin
      size_r <= size_nxt;
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_r   <= brf_act_t'(in_action);
      wbyte_r <= in_write_byte;
    end
  end

  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wp_r),
    .wdata (wbyte_r),
    .re    (cmd.rd_issue),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r   <= cmd.emit_byte ? ram_rdata : '0;
      out_status_r <= cmd.status;
      out_last_r   <= cmd.last;
      out_level_r  <= cmd.emit_byte ? fill_cur : fill_after;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_byte  = out_byte_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.fill_level = out_level_r;

  assign sts.act      = act_r;
  assign sts.full     = (wp_adv == rp_r);
  assign sts.empty    = (wp_r == rp_r);
  assign sts.out_free = !out_valid_r || out_ch.ready;

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (SIZE_W'(wp_r) < size_r) && (SIZE_W'(rp_r) < size_r))
    else $error("pointer beyond buffer size");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> !sts.full)
    else $error("slot written while full");

endmodule

### rtl/brf_ctrl.sv
// Controller: sequences each action and drives the datapath.
module brf_ctrl import brf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  brf_sts_t sts,
  output brf_cmd_t cmd
);

  brf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '{load_item: 1'b0, wr_en: 1'b0, clr: 1'b0, rd_issue: 1'b0,
                  emit: 1'b0, emit_byte: 1'b0, status: ST_OK, last: 1'b1};
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.act)
          ACT_WRITE: begin
            if (sts.out_free) begin
              cmd.emit   = 1'b1;
              cmd.status = sts.full ? ST_FULL : ST_OK;
              cmd.wr_en  = !sts.full;
              state_nxt  = S_IDLE;
            end
          end
          ACT_CLEAR: begin
            if (sts.out_free) begin
              cmd.emit  = 1'b1;
              cmd.clr   = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          ACT_READ, ACT_DRAIN: begin
            if (!sts.empty) begin
              cmd.rd_issue = 1'b1;
              state_nxt    = S_WAIT;
            end else if (sts.out_free) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_EMPTY;
              state_nxt  = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_WAIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_byte = 1'b1;
          cmd.last      = (sts.act != ACT_DRAIN) || sts.empty;
          if (sts.act == ACT_DRAIN && !sts.empty) begin
            cmd.rd_issue = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result loaded over an untaken one");

  a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |=> state_r == S_WAIT)
    else $error("memory read without wait state");

endmodule

### sim/tb.sv
// Self-checking testbench for byte_ring_fifo_core: random actions, sizes and flow control.
module tb;
  import brf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    brf_act_t          act;
    logic [BYTE_W-1:0] data;
    bit                pause;
  } fifo_req_t;

  typedef struct {
    logic [BYTE_W-1:0] rbyte;
    brf_status_t       sts;
    logic              last;
    logic [LVL_W-1:0]  level;
  } fifo_result_t;

  logic clk;
  logic rst_n;

  brf_in_if  in_ch();
  brf_out_if out_ch();
  brf_cfg_if cfg_ch();

  byte_ring_fifo_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  fifo_req_t    req_q[$];
  fifo_result_t due_results[$];

  logic [BYTE_W-1:0] ring_mem [DEPTH];
  logic [PTR_W-1:0]  ring_wr;
  logic [PTR_W-1:0]  ring_rd;
  logic [SIZE_W-1:0] ring_size;

  bit in_took;
  int mismatches;
  int idle_pct;
  int stall_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ERROR %s", $time, what);
  endtask

  function automatic int slots_for(int sz);
    return (sz < 2) ? 2 : (sz > DEPTH) ? DEPTH : sz;
  endfunction

  function automatic logic [LVL_W-1:0] held(int s);
    return LVL_W'((int'(ring_wr) + s - int'(ring_rd)) % s);
  endfunction

  function automatic logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p, int s);
    return (int'(p) + 1 >= s) ? '0 : p + 1'b1;
  endfunction

  // Works out the results of one accepted action and updates the ring state.
  function automatic void fifo_action_results(brf_act_t act, logic [BYTE_W-1:0] data);
    int           s;
    fifo_result_t r;
    s = slots_for(int'(ring_size));
    r.rbyte = '0;
    r.sts   = ST_OK;
    r.last  = 1'b1;
    r.level = '0;
    case (act)
      ACT_WRITE: begin
        if (step_ptr(ring_wr, s) == ring_rd) begin
          r.sts = ST_FULL;
        end else begin
          ring_mem[ring_wr] = data;
          ring_wr = step_ptr(ring_wr, s);
        end
        r.level = held(s);
        due_results.push_back(r);
      end
      ACT_READ: begin
        if (ring_rd == ring_wr) begin
          r.sts = ST_EMPTY;
        end else begin
          r.rbyte = ring_mem[ring_rd];
          ring_rd = step_ptr(ring_rd, s);
          r.level = held(s);
        end
        due_results.push_back(r);
      end
      ACT_CLEAR: begin
        ring_wr = '0;
        ring_rd = '0;
        due_results.push_back(r);
      end
      default: begin
        if (ring_rd == ring_wr) begin
          r.sts = ST_EMPTY;
          due_results.push_back(r);
        end
        while (ring_rd != ring_wr) begin
          r.rbyte = ring_mem[ring_rd];
          ring_rd = step_ptr(ring_rd, s);
          r.level = held(s);
          r.last  = (r.level == '0);
          due_results.push_back(r);
        end
      end
    endcase
  endfunction

  always @(negedge clk) begin : driver
    fifo_req_t nxt;
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && (!in_ch.valid || in_took)) begin
      if (req_q.size() != 0 && $urandom_range(99) >= idle_pct &&
          !(req_q[0].pause && due_results.size() != 0)) begin
        nxt = req_q.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.action     <= nxt.act;
        in_ch.write_byte <= nxt.data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    fifo_result_t got;
    fifo_result_t want;
    in_took = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        ring_size = cfg_ch.buffer_size;
        ring_wr   = '0;
        ring_rd   = '0;
      end
      if (in_took) begin
        fifo_action_results(brf_act_t'(in_ch.action), in_ch.write_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.rbyte = out_ch.read_byte;
        got.sts   = brf_status_t'(out_ch.status);
        got.last  = out_ch.last;
        got.level = out_ch.fill_level;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h sts %0d last %0b lvl %0d",
                                    got.rbyte, got.sts, got.last, got.level));
        end else begin
          want = due_results.pop_front();
          if (got.rbyte !== want.rbyte || got.sts !== want.sts ||
              got.last !== want.last || got.level !== want.level) begin
            report_mismatch($sformatf(
              "got byte %02h sts %0d last %0b lvl %0d, want %02h %0d %0b %0d",
              got.rbyte, got.sts, got.last, got.level,
              want.rbyte, want.sts, want.last, want.level));
          end
        end
      end
    end
  end

  task automatic add_item(brf_act_t act, logic [BYTE_W-1:0] data, bit pause);
    fifo_req_t r;
    r.act   = act;
    r.data  = data;
    r.pause = pause;
    req_q.push_back(r);
  endtask

  // Waits until every item is taken and every result is back, then flags any still missing.
  task automatic settle();
    int guard;
    guard = 0;
    while ((req_q.size() != 0 || in_ch.valid || due_results.size() != 0) &&
           guard < 50000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
    if (due_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));
    end
  endtask

  task automatic write_size(logic [SIZE_W-1:0] sz);
    settle();
    @(negedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.buffer_size <= sz;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Bursts of writes and reads so the ring fills, empties and wraps; some noise mixed in.
  task automatic random_phase(int budget, int cap);
    int made;
    int pick;
    int run;
    made = 0;
    while (made < budget) begin
      pick = $urandom_range(99);
      run  = $urandom_range(1, cap + 2);
      if (pick < 40) begin
        repeat (run) add_item(ACT_WRITE, BYTE_W'($urandom_range(255)), 1'b0);
      end else if (pick < 70) begin
        repeat (run) add_item(ACT_READ, BYTE_W'($urandom_range(255)), 1'b0);
      end else if (pick < 85) begin
        run = 1;
        add_item(ACT_DRAIN, BYTE_W'($urandom_range(255)), 1'b0);
      end else if (pick < 90) begin
        run = 1;
        add_item(ACT_CLEAR, BYTE_W'($urandom_range(255)), 1'b0);
      end else begin
        repeat (run) add_item(brf_act_t'($urandom_range(3)), BYTE_W'($urandom_range(255)),
                              1'b0);
      end
      made += run;
    end
  endtask

  initial begin : stimulus
    int sizes [8];
    int idle_mode [4];
    int stall_mode [4];
    int cap;
    sizes      = '{5, 1, 64, 9, 3, 127, 2, 17};
    idle_mode  = '{0, 50, 0, 27};
    stall_mode = '{0, 0, 50, 27};
    sizes[7]   = $urandom_range(2, 64);
    mismatches = 0;
    idle_pct   = 0;
    stall_pct  = 0;
    in_took    = 1'b0;
    ring_size  = SIZE_W'(DEPTH);
    ring_wr    = '0;
    ring_rd    = '0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_WRITE;
    in_ch.write_byte   = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.buffer_size = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // three usable slots: empty, full, wrap, drain and clear
    write_size(SIZE_W'(4));
    add_item(ACT_READ,  8'h00, 1'b0);
    add_item(ACT_DRAIN, 8'hFF, 1'b0);
    add_item(ACT_WRITE, 8'h00, 1'b0);
    add_item(ACT_WRITE, 8'hFF, 1'b0);
    add_item(ACT_WRITE, 8'h5A, 1'b0);
    add_item(ACT_WRITE, 8'h33, 1'b0);
    add_item(ACT_READ,  8'h00, 1'b0);
    add_item(ACT_WRITE, 8'hC3, 1'b0);
    add_item(ACT_DRAIN, 8'h00, 1'b0);
    add_item(ACT_READ,  8'hFF, 1'b0);
    add_item(ACT_WRITE, 8'h81, 1'b0);
    add_item(ACT_CLEAR, 8'hFF, 1'b0);
    add_item(ACT_READ,  8'h00, 1'b0);
    add_item(ACT_WRITE, 8'h7E, 1'b0);

    // size below range clamps to two slots; size write empties the ring
    write_size(SIZE_W'(0));
    add_item(ACT_READ,  8'h00, 1'b0);
    add_item(ACT_WRITE, 8'h11, 1'b0);
    add_item(ACT_WRITE, 8'h22, 1'b0);
    add_item(ACT_DRAIN, 8'h00, 1'b0);
    add_item(ACT_WRITE, 8'h44, 1'b0);
    add_item(ACT_READ,  8'h00, 1'b0);

    // size above range clamps to the full depth
    write_size(SIZE_W'(127));
    add_item(ACT_WRITE, 8'hAA, 1'b0);
    add_item(ACT_WRITE, 8'h55, 1'b0);
    add_item(ACT_DRAIN, 8'h00, 1'b0);

    for (int p = 0; p < 8; p++) begin
      write_size(SIZE_W'(sizes[p]));
      idle_pct  = idle_mode[p % 4];
      stall_pct = stall_mode[p % 4];
      cap = slots_for(sizes[p]) - 1;
      random_phase(18, cap);
      if (p == 2) begin
        add_item(ACT_READ, BYTE_W'($urandom_range(255)), 1'b1);
      end
      random_phase(18, cap);
    end

    settle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
